>>> rtl/battery_level_tracker_top_defines.svh
// Assertion macros for the checker file of the battery level tracker.
`ifndef BATTERY_LEVEL_TRACKER_TOP_DEFINES_SVH
`define BATTERY_LEVEL_TRACKER_TOP_DEFINES_SVH

// Checked at every rising edge outside reset.
`define BLT_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define BLT_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/blt_pkg.sv
`default_nettype none

package blt_pkg;

  localparam int SAMPLE_W = 12;
  localparam int VOLT_W   = 14;
  localparam int LEVEL_W  = 7;
  localparam int PSTATE_W = 2;

  // Command codes.
  localparam logic CMD_INIT    = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  // Power state codes.
  localparam logic [PSTATE_W-1:0] PS_BATTERY  = 2'd0;
  localparam logic [PSTATE_W-1:0] PS_CHARGING = 2'd1;
  localparam logic [PSTATE_W-1:0] PS_USB      = 2'd2;
  localparam logic [PSTATE_W-1:0] PS_FULL     = 2'd3;

  localparam logic [VOLT_W-1:0]  SCALE_OFS   = 14'd65;
  localparam int                 LEVEL_SHIFT = 3;
  localparam logic [VOLT_W-LEVEL_SHIFT-1:0] LEVEL_OFS = 11'd408;

  localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 7'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_CHG   = 7'd101;
  localparam logic [LEVEL_W-1:0] LEVEL_USB   = 7'd102;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd100;

  typedef struct packed {
    logic                cmd;
    logic [PSTATE_W-1:0] pstate;
  } item_t;

  // Battery voltage from the half-voltage ADC reading: twice the sample plus the offset.
  function automatic logic [VOLT_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] raw);
    return (VOLT_W'(raw) << 1) + SCALE_OFS;
  endfunction

endpackage

`default_nettype wire

>>> rtl/blt_if.sv
`default_nettype none

interface blt_in_if import blt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SAMPLE_W-1:0] sample_mv;
  logic [PSTATE_W-1:0] power_state;

  modport source (output valid, output cmd, output sample_mv, output power_state,
                  input ready);
  modport sink (input valid, input cmd, input sample_mv, input power_state,
                output ready);
  modport monitor (input valid, input ready, input cmd, input sample_mv,
                   input power_state);
endinterface

interface blt_out_if import blt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VOLT_W-1:0]  avg_voltage_mv;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output avg_voltage_mv, output level, input ready);
  modport sink (input valid, input avg_voltage_mv, input level, output ready);
  modport monitor (input valid, input ready, input avg_voltage_mv, input level);
endinterface

`default_nettype wire

>>> rtl/blt_ring.sv
`default_nettype none

module blt_ring import blt_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  acc,
  input  wire logic                                  cmd,
  input  wire logic [VOLT_W-1:0]                     scaled,
  output logic      [VOLT_W+$clog2(DEPTH)-1:0]       sum_next
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int SUM_W  = VOLT_W + SLOT_W;

  logic [VOLT_W-1:0] mem [DEPTH];
  logic [VOLT_W-1:0] rd_data;
  logic [DEPTH-1:0]  written;
  logic [VOLT_W-1:0] fill_value;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [SUM_W-1:0]  sum;
  logic [VOLT_W-1:0] old_value;
  logic              do_measure;
  logic              do_init;

  assign do_measure = acc && (cmd == CMD_MEASURE);
  assign do_init    = acc && (cmd == CMD_INIT);

  always_comb begin
    slot_next = slot;
    if (do_measure) begin
      slot_next = (slot == SLOT_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
    end
  end

  // The read port always fetches the slot that the next measure will overwrite,
  // so its old content is ready when that transaction arrives.
  always_ff @(posedge clk) begin
    if (do_measure) begin
      mem[slot] <= scaled;
    end
    rd_data <= mem[slot_next];
  end

  // A slot not written since the last init holds the fill value.
  assign old_value = written[slot] ? rd_data : fill_value;

  always_comb begin
    sum_next = sum;
    if (do_init) begin
      sum_next = SUM_W'(scaled) * SUM_W'(DEPTH);
    end else if (do_measure) begin
      sum_next = sum - SUM_W'(old_value) + SUM_W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      fill_value <= '0;
      slot       <= '0;
      sum        <= '0;
    end else begin
      slot <= slot_next;
      sum  <= sum_next;
      if (do_init) begin
        written    <= '0;
        fill_value <= scaled;
      end else if (do_measure) begin
        written[slot] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/blt_level.sv
`default_nettype none

module blt_level import blt_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            acc,
  input  wire item_t                           item,
  input  wire logic [VOLT_W+$clog2(DEPTH)-1:0] sum_next,
  output logic                                 in_ready,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [VOLT_W-1:0]               avg,
  output logic      [LEVEL_W-1:0]              level
);

  localparam int L     = $clog2(DEPTH);
  localparam int SUM_W = VOLT_W + L;
  // Exact division by DEPTH: multiply by ceil(2^K / DEPTH) and drop K bits.
  localparam int K      = SUM_W + L;
  localparam int REC_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + REC_W;
  localparam logic [REC_W-1:0] RECIP = REC_W'(((1 << K) + DEPTH - 1) / DEPTH);
  localparam int Q_W    = VOLT_W - LEVEL_SHIFT;

  logic              s1_valid;
  item_t             s1_item;
  logic [SUM_W-1:0]  s1_sum;
  logic              s2_valid;
  item_t             s2_item;
  logic [PROD_W-1:0] s2_prod;
  logic              o_valid;
  logic [VOLT_W-1:0] o_avg;
  logic [LEVEL_W-1:0] o_level;
  logic [LEVEL_W-1:0] level_last;
  logic [LEVEL_W-1:0] level_next;

  logic              o_ready;
  logic              s2_ready;
  logic              s1_ready;
  logic [VOLT_W-1:0] s2_avg;
  logic [Q_W-1:0]    q8;
  logic [Q_W-1:0]    cand;
  logic              cand_ok;

  assign o_ready  = !o_valid || out_ready;
  assign s2_ready = !s2_valid || o_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  assign s2_avg = s2_prod[K +: VOLT_W];
  assign q8     = s2_avg[VOLT_W-1:LEVEL_SHIFT];
  assign cand   = q8 - LEVEL_OFS;
  // A candidate below the offset would wrap to a large value and is refused.
  assign cand_ok = (q8 >= LEVEL_OFS) && (cand <= Q_W'(LEVEL_FULL))
                   && (cand <= Q_W'(level_last));

  always_comb begin
    level_next = level_last;
    if (s2_item.cmd == CMD_MEASURE) begin
      unique case (s2_item.pstate)
        PS_CHARGING: level_next = LEVEL_CHG;
        PS_USB:      level_next = LEVEL_USB;
        PS_FULL:     level_next = LEVEL_FULL;
        PS_BATTERY: begin
          if (level_last <= LEVEL_MIN) begin
            level_next = LEVEL_MIN;
          end else if (cand_ok) begin
            level_next = cand[LEVEL_W-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && acc) begin
      s1_item <= item;
      s1_sum  <= sum_next;
    end
    if (s2_ready && s1_valid) begin
      s2_item <= s1_item;
      s2_prod <= PROD_W'(s1_sum) * PROD_W'(RECIP);
    end
    if (o_ready && s2_valid) begin
      o_avg   <= s2_avg;
      o_level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      o_valid    <= 1'b0;
      level_last <= LEVEL_RESET;
    end else begin
      if (s1_ready) begin
        s1_valid <= acc;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (o_ready) begin
        o_valid <= s2_valid;
        if (s2_valid) begin
          level_last <= level_next;
        end
      end
    end
  end

  assign out_valid = o_valid;
  assign avg       = o_avg;
  assign level     = o_level;

endmodule

`default_nettype wire

>>> rtl/battery_level_tracker_top.sv
// Battery level tracker: each input transaction carries an ADC sample, a command and the
// power state, and yields exactly one result with the moving average of the scaled
// voltage over AVG_DEPTH samples and a percent level that only falls while on battery.
// One transaction is accepted every cycle while the pipeline has room; its result passes
// through the s1, s2 and output registers, and the input keeps accepting while results
// wait until the three pipeline stages are full. The rate is set by the
// averaging ring: a memory with one write port and one read port, whose read port
// prefetches the next slot to be overwritten, and a running sum updated in the cycle of
// acceptance. Division by AVG_DEPTH is an exact reciprocal multiply in its own stage.
// Init is accepted like any other command: per-slot valid bits stand in for
// refilling the memory, so there is no clearing pass after reset.
`default_nettype none

module battery_level_tracker_top import blt_pkg::*; #(
  parameter int AVG_DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  blt_in_if.sink    in_ch,
  blt_out_if.source out_ch
);

  localparam int SUM_W = VOLT_W + $clog2(AVG_DEPTH);

  logic              acc;
  logic              in_ready;
  logic [VOLT_W-1:0] scaled;
  logic [SUM_W-1:0]  sum_next;
  item_t             item;

  assign acc    = in_ch.valid && in_ready;
  assign scaled = scale_sample(in_ch.sample_mv);
  assign item   = '{cmd: in_ch.cmd, pstate: in_ch.power_state};
  assign in_ch.ready = in_ready;

  blt_ring #(.DEPTH(AVG_DEPTH)) u_ring (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .cmd      (in_ch.cmd),
    .scaled   (scaled),
    .sum_next (sum_next)
  );

  blt_level #(.DEPTH(AVG_DEPTH)) u_level (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .item      (item),
    .sum_next  (sum_next),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .avg       (out_ch.avg_voltage_mv),
    .level     (out_ch.level)
  );

endmodule

`default_nettype wire

>>> rtl/blt_checker.sv
`default_nettype none
`include "battery_level_tracker_top_defines.svh"

module blt_checker import blt_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [VOLT_W-1:0]  out_avg,
  input wire logic [LEVEL_W-1:0] out_level
);

  localparam logic [VOLT_W-1:0] AVG_MAX = 14'd8255;

  `BLT_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid,
    "result dropped while stalled")
  `BLT_ASSERT_RUN(a_out_stable,
    out_valid && !out_ready |=> $stable(out_avg) && $stable(out_level),
    "stalled result changed")
  `BLT_ASSERT_RUN(a_backpressure, !in_ready |-> out_valid && !out_ready,
    "input refused with an empty or moving output")
  `BLT_ASSERT_ALL(a_reset_empty, rst |=> !out_valid,
    "result presented straight after reset")
  `BLT_ASSERT_RUN(a_range,
    out_valid |-> (out_level <= LEVEL_USB) && (out_avg <= AVG_MAX),
    "result out of range")

endmodule

bind battery_level_tracker_top blt_checker u_blt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_avg   (out_ch.avg_voltage_mv),
  .out_level (out_ch.level)
);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import blt_pkg::*;

  localparam int AVG_DEPTH    = 8;
  localparam int SLOT_W       = $clog2(AVG_DEPTH);
  localparam int SUM_W        = VOLT_W + SLOT_W;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_AT      = 900;
  localparam int HOLD_CYCLES  = 120;
  localparam int IDLE_PCT     = 21;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [VOLT_W-1:0]  avg;
    logic [LEVEL_W-1:0] level;
  } reading_t;

  // Tracks the ring, the running sum and the level as the block should, and queues the
  // reading that each accepted transaction must produce.
  class level_scoreboard;
    logic [VOLT_W-1:0]  ring [AVG_DEPTH];
    logic [SLOT_W-1:0]  slot;
    logic [SUM_W-1:0]   sum;
    logic [LEVEL_W-1:0] level_last;
    reading_t           expected_q[$];
    int                 errors;

    function new();
      for (int i = 0; i < AVG_DEPTH; i++) ring[i] = '0;
      slot       = '0;
      sum        = '0;
      level_last = LEVEL_RESET;
      errors     = 0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    task report(input string what);
      if (errors < MAX_PRINTS) $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    function void note_input(input logic cmd, input logic [SAMPLE_W-1:0] raw,
                             input logic [PSTATE_W-1:0] ps);
      logic [VOLT_W-1:0] scaled;
      logic [VOLT_W-1:0] avg;
      logic [15:0]       cand;
      reading_t          r;
      scaled = (VOLT_W'(raw) * VOLT_W'(2)) + VOLT_W'(65);
      if (cmd == CMD_INIT) begin
        for (int i = 0; i < AVG_DEPTH; i++) ring[i] = scaled;
        sum = SUM_W'(scaled) * SUM_W'(AVG_DEPTH);
        avg = scaled;
      end else begin
        sum = sum - SUM_W'(ring[slot]) + SUM_W'(scaled);
        ring[slot] = scaled;
        if (slot == SLOT_W'(AVG_DEPTH - 1)) slot = '0;
        else slot = slot + 1'b1;
        avg = VOLT_W'(sum / AVG_DEPTH);
        // An average below the offset wraps to a large candidate, which is then rejected.
        cand = 16'(avg >> 3) - 16'(LEVEL_OFS);
        if (ps == PS_CHARGING) begin
          level_last = LEVEL_CHG;
        end else if (ps == PS_USB) begin
          level_last = LEVEL_USB;
        end else if (ps == PS_FULL) begin
          level_last = LEVEL_FULL;
        end else if (level_last <= LEVEL_MIN) begin
          level_last = LEVEL_MIN;
        end else if (cand <= 16'(level_last) && cand <= 16'(LEVEL_FULL)) begin
          level_last = cand[LEVEL_W-1:0];
        end
      end
      r.avg   = avg;
      r.level = level_last;
      expected_q.push_back(r);
    endfunction

    task check_result(input logic [VOLT_W-1:0] avg, input logic [LEVEL_W-1:0] level);
      reading_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected reading avg=%0d level=%0d", avg, level));
        return;
      end
      want = expected_q.pop_front();
      if (avg !== want.avg)
        report($sformatf("avg_voltage_mv %0d, wanted %0d", avg, want.avg));
      if (level !== want.level)
        report($sformatf("level %0d, wanted %0d", level, want.level));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  int   results_seen;
  int   cycles;
  int   hold_left;
  bit   held;

  level_scoreboard sb = new();

  blt_in_if  in_ch ();
  blt_out_if out_ch ();

  battery_level_tracker_top #(.AVG_DEPTH(AVG_DEPTH)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] raw,
                           input logic [PSTATE_W-1:0] ps);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid       <= 1'b0;
      in_ch.cmd         <= 1'($urandom_range(1));
      in_ch.sample_mv   <= SAMPLE_W'($urandom);
      in_ch.power_state <= PSTATE_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.sample_mv   <= raw;
    in_ch.power_state <= ps;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(cmd, raw, ps);
    @(negedge clk);
  endtask

  // The receiver stalls once for a long stretch so that the pipeline fills and the input
  // stops taking transactions.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!held && results_seen >= HOLD_AT) begin
      held      = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.avg_voltage_mv, out_ch.level);
      results_seen++;
    end
  end

  initial begin : stimulus
    int                  sent;
    int                  n;
    int                  drift;
    logic [PSTATE_W-1:0] ps;
    clk               = 1'b0;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_INIT;
    in_ch.sample_mv   = '0;
    in_ch.power_state = PS_BATTERY;
    out_ch.ready      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Measuring before any init averages against the zeros left by reset.
    send_item(CMD_MEASURE, 12'd4095, PS_BATTERY);
    send_item(CMD_MEASURE, 12'd0, PS_CHARGING);
    send_item(CMD_MEASURE, 12'hAAA, PS_USB);
    send_item(CMD_MEASURE, 12'h555, PS_FULL);
    send_item(CMD_INIT, 12'd4095, PS_BATTERY);
    send_item(CMD_INIT, 12'd0, PS_CHARGING);
    // Top of the battery range: the candidate is exactly full.
    send_item(CMD_INIT, 12'd2003, PS_BATTERY);
    send_item(CMD_MEASURE, 12'd2003, PS_BATTERY);
    send_item(CMD_INIT, 12'd1800, PS_BATTERY);
    send_item(CMD_MEASURE, 12'd1800, PS_BATTERY);
    send_item(CMD_MEASURE, 12'd1900, PS_BATTERY);
    // An average of exactly the offset gives zero, then the level sticks at one.
    send_item(CMD_INIT, 12'd1600, PS_BATTERY);
    send_item(CMD_MEASURE, 12'd1600, PS_BATTERY);
    send_item(CMD_MEASURE, 12'd1600, PS_BATTERY);
    send_item(CMD_MEASURE, 12'd2003, PS_BATTERY);
    send_item(CMD_MEASURE, 12'd1599, PS_BATTERY);
    send_item(CMD_MEASURE, 12'd2003, PS_CHARGING);
    send_item(CMD_INIT, 12'd2003, PS_USB);
    send_item(CMD_MEASURE, 12'd2003, PS_BATTERY);
    // Further measures carry the write slot round past the end of the ring.
    for (int k = 0; k < 6; k++) send_item(CMD_MEASURE, 12'd1700 - 12'(k * 30), PS_BATTERY);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 80) begin
        // Mostly an init near the battery range, then a slowly falling series of measures.
        drift = $urandom_range(1590, 2020);
        if ($urandom_range(3) != 0) begin
          quiet = (sent >= 600 && sent < 1000);
          send_item(CMD_INIT, SAMPLE_W'(drift), PS_BATTERY);
          sent++;
        end
        n = $urandom_range(4, 40);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(9) == 0) drift = drift + $urandom_range(0, 20);
          else drift = drift - $urandom_range(0, 4);
          if (drift < 0) drift = 0;
          if (drift > 4095) drift = 4095;
          ps = ($urandom_range(19) == 0) ? PSTATE_W'($urandom) : PS_BATTERY;
          quiet = (sent >= 600 && sent < 1000);
          send_item(CMD_MEASURE, SAMPLE_W'(drift), ps);
          sent++;
        end
      end else begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          quiet = (sent >= 600 && sent < 1000);
          send_item(1'($urandom_range(1)), SAMPLE_W'($urandom), PSTATE_W'($urandom));
          sent++;
        end
      end
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/blt_pkg.sv
rtl/blt_if.sv
rtl/blt_ring.sv
rtl/blt_level.sv
rtl/battery_level_tracker_top.sv
rtl/blt_checker.sv
dv/tb.sv
